[design/single_cycle_rv64i_subset_core_unit_macros.svh]
// Assertion macros for the RV64I subset core.
// Included by the top level; depends on nothing else.
`ifndef SINGLE_CYCLE_RV64I_SUBSET_CORE_UNIT_MACROS_SVH
`define SINGLE_CYCLE_RV64I_SUBSET_CORE_UNIT_MACROS_SVH
`define RV_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
`define RV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`endif

[design/rv64s_pkg.sv]
// Shared types and constants for the RV64I subset core.
// Used by the front, queue, back and top modules.
package rv64s_pkg;
	localparam int DMEM_DEPTH_DEF = 256;
	localparam int QDEPTH = 2;
	localparam logic [6:0] OP_R = 7'h33;
	localparam logic [6:0] OP_I = 7'h13;
	localparam logic [6:0] OP_LD = 7'h03;
	localparam logic [6:0] OP_SD = 7'h23;
	localparam logic [6:0] OP_BR = 7'h63;
	localparam logic [6:0] F7_SUB = 7'b0100000;
	localparam logic [2:0] F3_D = 3'd3;

	localparam logic [2:0] K_ALU = 3'd0;
	localparam logic [2:0] K_LD = 3'd1;
	localparam logic [2:0] K_SD = 3'd2;
	localparam logic [2:0] K_BR = 3'd3;
	localparam logic [2:0] K_ILL = 3'd4;

	typedef struct packed {
		logic [2:0] kind;
		logic [2:0] f3;
		logic sub;
		logic use_imm;
		logic [4:0] rd;
		logic [4:0] rs1;
		logic [4:0] rs2;
		logic [63:0] imm;
	} dec_t;
endpackage

[design/rv64s_front.sv]
// Front end: accepts instructions and classifies them into decoded beats.
// Depends on rv64s_pkg.
module rv64s_front import rv64s_pkg::*; (
	input logic [31:0] instruction,
	output dec_t dec
);
	logic [6:0] op;
	logic [2:0] f3;
	logic [6:0] f7;
	always_comb begin
		op = instruction[6:0];
		f3 = instruction[14:12];
		f7 = instruction[31:25];
		dec = '0;
		dec.f3 = f3;
		dec.rd = instruction[11:7];
		dec.rs1 = instruction[19:15];
		dec.rs2 = instruction[24:20];
		dec.kind = K_ILL;
		case (op)
			OP_R: begin
				if (f3 == 3'd0 && f7 == F7_SUB) begin
					dec.kind = K_ALU;
					dec.sub = 1'b1;
				end else if (f7 == 7'd0 && f3 != 3'd3) begin
					dec.kind = K_ALU;
				end
			end
			OP_I: begin
				dec.use_imm = 1'b1;
				dec.imm = {{52{instruction[31]}}, instruction[31:20]};
				if (f3 == 3'd3) dec.kind = K_ILL;
				else if ((f3 == 3'd1 || f3 == 3'd5) && instruction[31:26] != 6'd0)
					dec.kind = K_ILL;
				else dec.kind = K_ALU;
			end
			OP_LD: begin
				dec.imm = {{52{instruction[31]}}, instruction[31:20]};
				if (f3 == F3_D) dec.kind = K_LD;
			end
			OP_SD: begin
				dec.imm = {{52{instruction[31]}}, instruction[31:25], instruction[11:7]};
				if (f3 == F3_D) dec.kind = K_SD;
			end
			OP_BR: begin
				dec.imm = {{51{instruction[31]}}, instruction[31], instruction[7],
					instruction[30:25], instruction[11:8], 1'b0};
				if (f3 != 3'd2 && f3 != 3'd3) dec.kind = K_BR;
			end
			default: dec.kind = K_ILL;
		endcase
	end
endmodule

[design/rv64s_queue.sv]
// Short queue of decoded beats between the front and back ends.
// Depends on rv64s_pkg.
module rv64s_queue import rv64s_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input dec_t in_data,
	output logic out_valid,
	input logic out_ready,
	output dec_t out_data
);
	dec_t mem_q [QDEPTH];
	logic [$clog2(QDEPTH)-1:0] wp_q, rp_q;
	logic [$clog2(QDEPTH):0] cnt_q;
	logic push, pop;
	assign in_ready = cnt_q != QDEPTH[$clog2(QDEPTH):0];
	assign out_valid = cnt_q != '0;
	assign out_data = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {{$clog2(QDEPTH){1'b0}}, push} - {{$clog2(QDEPTH){1'b0}}, pop};
		end
	end
endmodule

[design/rv64s_back.sv]
// Back end: register file, data memory, ALU, branch unit and result register.
// Depends on rv64s_pkg.
module rv64s_back import rv64s_pkg::*; #(
	parameter int DMEM_DEPTH = DMEM_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic [31:0] last_instr_addr,
	input logic in_valid,
	output logic in_ready,
	input dec_t in_data,
	output logic out_valid,
	input logic out_ready,
	output logic [31:0] pc,
	output logic [31:0] next_pc,
	output logic reg_write,
	output logic [4:0] dest_reg,
	output logic signed [63:0] write_value,
	output logic mem_write,
	output logic [7:0] mem_address,
	output logic branch_taken,
	output logic illegal,
	output logic mem_fault,
	output logic running
);
	localparam int AW = $clog2(DMEM_DEPTH);
	logic [63:0] rf_q [32];
	logic [63:0] dm_q [DMEM_DEPTH];
	logic [63:0] rdata_q, wv_q;
	logic ldw_q, outld_q, clr_busy_q;
	logic [4:0] ldrd_q;
	logic [AW-1:0] clr_q;
	logic [31:0] pc_q;
	logic [63:0] ra, rb, a, b, opb, alu, ea, wv;
	logic wr, mw, tk, ill, flt, memop, go, lts, ltu, ldw;
	logic [31:0] nxt;
	logic [AW-1:0] ai;
	assign in_ready = !clr_busy_q && (!out_valid || out_ready);
	assign go = in_valid && in_ready;
	assign write_value = outld_q ? rdata_q : wv_q;
	always_comb begin
		ra = rf_q[in_data.rs1];
		rb = rf_q[in_data.rs2];
		// A load retired last cycle has its data in rdata_q until the register file takes it.
		a = (ldw_q && ldrd_q == in_data.rs1) ? rdata_q : ra;
		b = (ldw_q && ldrd_q == in_data.rs2) ? rdata_q : rb;
		opb = in_data.use_imm ? in_data.imm : b;
		lts = $signed(a) < $signed(opb);
		ltu = a < b;
		case (in_data.f3)
			3'd0: alu = in_data.sub ? a - opb : a + opb;
			3'd1: alu = a << opb[5:0];
			3'd2: alu = {63'd0, lts};
			3'd4: alu = a ^ opb;
			3'd5: alu = a >> opb[5:0];
			3'd6: alu = a | opb;
			default: alu = a & opb;
		endcase
		ea = a + in_data.imm;
		ai = ea[AW-1:0];
		wr = 1'b0; mw = 1'b0; tk = 1'b0; ill = 1'b0; flt = 1'b0; memop = 1'b0;
		wv = alu;
		nxt = pc_q + 32'd4;
		case (in_data.kind)
			K_ALU: wr = 1'b1;
			K_LD: begin
				memop = 1'b1;
				wv = 64'd0;
				if (ea < 64'(DMEM_DEPTH)) wr = 1'b1; else flt = 1'b1;
			end
			K_SD: begin
				memop = 1'b1;
				if (ea < 64'(DMEM_DEPTH)) mw = 1'b1; else flt = 1'b1;
			end
			K_BR: begin
				case (in_data.f3)
					3'd0: tk = a == b;
					3'd1: tk = a != b;
					3'd4: tk = $signed(a) < $signed(b);
					3'd5: tk = !($signed(a) < $signed(b));
					3'd6: tk = ltu;
					default: tk = !ltu;
				endcase
				if (tk) nxt = pc_q + in_data.imm[31:0];
			end
			default: ill = 1'b1;
		endcase
		if (in_data.rd == 5'd0) wr = 1'b0;
		if (!wr) wv = 64'd0;
		ldw = wr && (in_data.kind == K_LD);
	end
	always_ff @(posedge clk) begin
		if (clr_busy_q) dm_q[clr_q] <= 64'd0;
		else if (go && mw) dm_q[ai] <= b;
		if (go) rdata_q <= dm_q[ai];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 32; i++) rf_q[i] <= 64'd0;
			clr_q <= '0;
			clr_busy_q <= 1'b1;
			ldw_q <= 1'b0;
			ldrd_q <= 5'd0;
			pc_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == AW'(DMEM_DEPTH - 1)) clr_busy_q <= 1'b0;
			end
			if (ldw_q && !(go && wr && in_data.rd == ldrd_q)) rf_q[ldrd_q] <= rdata_q;
			if (go) begin
				if (wr && !ldw) rf_q[in_data.rd] <= wv;
				ldw_q <= ldw;
				ldrd_q <= in_data.rd;
				pc_q <= nxt;
				out_valid <= 1'b1;
			end else begin
				ldw_q <= 1'b0;
				if (out_ready) out_valid <= 1'b0;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (go) begin
			pc <= pc_q;
			next_pc <= nxt;
			reg_write <= wr;
			dest_reg <= wr ? in_data.rd : 5'd0;
			wv_q <= wv;
			outld_q <= ldw;
			mem_write <= mw;
			mem_address <= memop ? ea[7:0] : 8'd0;
			branch_taken <= tk;
			illegal <= ill;
			mem_fault <= flt;
			running <= nxt <= last_instr_addr;
		end
	end
endmodule

[design/single_cycle_rv64i_subset_core_unit.sv]
// RV64I subset core: decode front end, two-entry queue, execute back end.
// A beat is queued, then executed into registered results; one beat per cycle when not stalled.
// The back end issues one instruction per cycle unless the result side or the memory clear stalls
// it; load data comes from a registered memory read. Reset clears the PC, register file and queue;
// the data memory (DMEM_DEPTH entries, 256 by default) is then cleared, and no instruction executes
// meanwhile. last_instr_addr resets to 0xFFFFFFFC. Depends on rv64s_pkg and the macros header.
`include "single_cycle_rv64i_subset_core_unit_macros.svh"
module single_cycle_rv64i_subset_core_unit import rv64s_pkg::*; #(
	parameter int DMEM_DEPTH = DMEM_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input logic [31:0] instruction,
	output logic out_valid,
	input logic out_ready,
	output logic [31:0] pc,
	output logic [31:0] next_pc,
	output logic reg_write,
	output logic [4:0] dest_reg,
	output logic signed [63:0] write_value,
	output logic mem_write,
	output logic [7:0] mem_address,
	output logic branch_taken,
	output logic illegal,
	output logic mem_fault,
	output logic running
);
	logic [31:0] last_q;
	dec_t dec, qd;
	logic qv, qr;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) last_q <= 32'hFFFF_FFFC;
		else if (cfg_we) last_q <= cfg_wdata;
	end
	rv64s_front u_front (.instruction(instruction), .dec(dec));
	rv64s_queue u_queue (.clk(clk), .arst_n(arst_n), .in_valid(in_valid),
		.in_ready(in_ready), .in_data(dec), .out_valid(qv), .out_ready(qr),
		.out_data(qd));
	rv64s_back #(.DMEM_DEPTH(DMEM_DEPTH)) u_back (.clk(clk), .arst_n(arst_n),
		.last_instr_addr(last_q), .in_valid(qv), .in_ready(qr), .in_data(qd),
		.out_valid(out_valid), .out_ready(out_ready), .pc(pc), .next_pc(next_pc),
		.reg_write(reg_write), .dest_reg(dest_reg), .write_value(write_value),
		.mem_write(mem_write), .mem_address(mem_address),
		.branch_taken(branch_taken), .illegal(illegal), .mem_fault(mem_fault),
		.running(running));

	`RV_ASSERT_IMPL(a_wr_nz, out_valid && reg_write, dest_reg != 5'd0, "write to x0 reported")
	`RV_ASSERT_IMPL(a_excl, out_valid, !(mem_write && mem_fault), "store both wrote and faulted")
	`RV_ASSERT_NEXT(a_chain, out_valid && out_ready && qv && qr, pc == $past(next_pc), "pc chain")
endmodule

[sim/rv64s_core_checker.sv]
// Checker for the RV64I subset core: watches both channels, predicts each retired result
// with its own copy of PC, register file and data memory, and compares field by field.
// Depends on rv64s_pkg for the opcode constants.
module rv64s_core_checker import rv64s_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	input logic in_valid,
	input logic in_ready,
	input logic [31:0] instruction,
	input logic out_valid,
	input logic out_ready,
	input logic [31:0] pc,
	input logic [31:0] next_pc,
	input logic reg_write,
	input logic [4:0] dest_reg,
	input logic signed [63:0] write_value,
	input logic mem_write,
	input logic [7:0] mem_address,
	input logic branch_taken,
	input logic illegal,
	input logic mem_fault,
	input logic running,
	output int fail_count,
	output int pending,
	output int retired
);
	typedef struct packed {
		logic [31:0] pc;
		logic [31:0] next_pc;
		logic reg_write;
		logic [4:0] dest_reg;
		logic [63:0] write_value;
		logic mem_write;
		logic [7:0] mem_address;
		logic branch_taken;
		logic illegal;
		logic mem_fault;
		logic running;
	} retire_t;

	retire_t retire_q[$];
	logic [31:0] m_last;
	logic [31:0] m_pc;
	logic [63:0] m_regs[32];
	logic [63:0] m_dmem[256];

	function automatic logic [63:0] alu_calc(input logic [2:0] f3, input logic sub,
			input logic [63:0] a, input logic [63:0] b);
		case (f3)
			3'd0: alu_calc = sub ? a - b : a + b;
			3'd1: alu_calc = a << b[5:0];
			3'd2: alu_calc = {63'd0, $signed(a) < $signed(b)};
			3'd4: alu_calc = a ^ b;
			3'd5: alu_calc = a >> b[5:0];
			3'd6: alu_calc = a | b;
			default: alu_calc = a & b;
		endcase
	endfunction

	task automatic execute_instruction(input logic [31:0] ins);
		logic [6:0] op;
		logic [4:0] rd;
		logic [2:0] f3;
		logic [6:0] f7;
		logic [63:0] a, b, imm, val, ea;
		logic wr, memop;
		retire_t r;
		op = ins[6:0];
		rd = ins[11:7];
		f3 = ins[14:12];
		f7 = ins[31:25];
		a = m_regs[ins[19:15]];
		b = m_regs[ins[24:20]];
		r = '0;
		r.pc = m_pc;
		r.next_pc = m_pc + 32'd4;
		wr = 1'b0;
		memop = 1'b0;
		val = '0;
		ea = '0;
		if (op == OP_R) begin
			if (f3 == 3'd0 && f7 == F7_SUB) begin
				val = alu_calc(3'd0, 1'b1, a, b);
				wr = 1'b1;
			end else if (f7 == 7'd0 && f3 != 3'd3) begin
				val = alu_calc(f3, 1'b0, a, b);
				wr = 1'b1;
			end else begin
				r.illegal = 1'b1;
			end
		end else if (op == OP_I) begin
			imm = {{52{ins[31]}}, ins[31:20]};
			if (f3 == 3'd3 || ((f3 == 3'd1 || f3 == 3'd5) && ins[31:26] != 6'd0)) begin
				r.illegal = 1'b1;
			end else begin
				val = alu_calc(f3, 1'b0, a, imm);
				wr = 1'b1;
			end
		end else if ((op == OP_LD || op == OP_SD) && f3 == F3_D) begin
			memop = 1'b1;
			if (op == OP_LD)
				imm = {{52{ins[31]}}, ins[31:20]};
			else
				imm = {{52{ins[31]}}, ins[31:25], ins[11:7]};
			ea = a + imm;
			if (ea < 64'd256) begin
				if (op == OP_LD) begin
					val = m_dmem[ea[7:0]];
					wr = 1'b1;
				end else begin
					m_dmem[ea[7:0]] = b;
					r.mem_write = 1'b1;
				end
			end else begin
				r.mem_fault = 1'b1;
			end
		end else if (op == OP_BR && f3 != 3'd2 && f3 != 3'd3) begin
			imm = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
			case (f3)
				3'd0: r.branch_taken = a == b;
				3'd1: r.branch_taken = a != b;
				3'd4: r.branch_taken = $signed(a) < $signed(b);
				3'd5: r.branch_taken = $signed(a) >= $signed(b);
				3'd6: r.branch_taken = a < b;
				default: r.branch_taken = a >= b;
			endcase
			if (r.branch_taken)
				r.next_pc = m_pc + imm[31:0];
		end else begin
			r.illegal = 1'b1;
		end
		if (wr && rd != 5'd0) begin
			m_regs[rd] = val;
			r.reg_write = 1'b1;
			r.dest_reg = rd;
			r.write_value = val;
		end
		r.mem_address = memop ? ea[7:0] : 8'd0;
		r.running = r.next_pc <= m_last;
		m_pc = r.next_pc;
		retire_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		retire_t e;
		if (!arst_n) begin
			retire_q.delete();
			m_last = 32'hFFFF_FFFC;
			m_pc = '0;
			foreach (m_regs[i])
				m_regs[i] = '0;
			foreach (m_dmem[i])
				m_dmem[i] = '0;
			fail_count <= 0;
			retired <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (retire_q.size() == 0) begin
					$error("result beat with nothing expected, pc %h", pc);
					fail_count <= fail_count + 1;
				end else begin
					e = retire_q.pop_front();
					if ({pc, next_pc, reg_write, dest_reg, write_value, mem_write, mem_address,
							branch_taken, illegal, mem_fault, running} !== e) begin
						if (pc !== e.pc) $error("pc exp %h got %h", e.pc, pc);
						if (next_pc !== e.next_pc)
							$error("next_pc exp %h got %h", e.next_pc, next_pc);
						if (reg_write !== e.reg_write)
							$error("reg_write exp %b got %b", e.reg_write, reg_write);
						if (dest_reg !== e.dest_reg)
							$error("dest_reg exp %0d got %0d", e.dest_reg, dest_reg);
						if (write_value !== e.write_value)
							$error("write_value exp %h got %h", e.write_value, write_value);
						if (mem_write !== e.mem_write)
							$error("mem_write exp %b got %b", e.mem_write, mem_write);
						if (mem_address !== e.mem_address)
							$error("mem_address exp %h got %h", e.mem_address, mem_address);
						if (branch_taken !== e.branch_taken)
							$error("branch_taken exp %b got %b", e.branch_taken, branch_taken);
						if (illegal !== e.illegal)
							$error("illegal exp %b got %b", e.illegal, illegal);
						if (mem_fault !== e.mem_fault)
							$error("mem_fault exp %b got %b", e.mem_fault, mem_fault);
						if (running !== e.running)
							$error("running exp %b got %b", e.running, running);
						fail_count <= fail_count + 1;
					end
					retired <= retired + 1;
				end
			end
			if (in_valid && in_ready)
				execute_instruction(instruction);
			if (cfg_we)
				m_last = cfg_wdata;
		end
	end

	assign pending = retire_q.size();
endmodule

[sim/tb.sv]
// Top of the RV64I subset core testbench: clock, reset, instruction stimulus and verdict.
// Depends on rv64s_pkg, the core and rv64s_core_checker.
module tb;
	import rv64s_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [31:0] instruction = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] pc, next_pc;
	logic reg_write, mem_write, branch_taken, illegal, mem_fault, running;
	logic [4:0] dest_reg;
	logic signed [63:0] write_value;
	logic [7:0] mem_address;
	int fail_count, pending, retired;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;
	int cycles = 0;
	int sent = 0;
	int taken_cnt = 0;
	int fault_cnt = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	single_cycle_rv64i_subset_core_unit u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .instruction(instruction),
		.out_valid(out_valid), .out_ready(out_ready), .pc(pc), .next_pc(next_pc),
		.reg_write(reg_write), .dest_reg(dest_reg), .write_value(write_value),
		.mem_write(mem_write), .mem_address(mem_address), .branch_taken(branch_taken),
		.illegal(illegal), .mem_fault(mem_fault), .running(running)
	);

	rv64s_core_checker u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .instruction(instruction),
		.out_valid(out_valid), .out_ready(out_ready), .pc(pc), .next_pc(next_pc),
		.reg_write(reg_write), .dest_reg(dest_reg), .write_value(write_value),
		.mem_write(mem_write), .mem_address(mem_address), .branch_taken(branch_taken),
		.illegal(illegal), .mem_fault(mem_fault), .running(running),
		.fail_count(fail_count), .pending(pending), .retired(retired)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (out_valid && out_ready) begin
			taken_cnt <= taken_cnt + branch_taken;
			fault_cnt <= fault_cnt + mem_fault;
		end
		if (cycles > 200000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else
			out_ready <= $urandom_range(99) >= recv_stall_pct;
	end

	function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
			input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd,
			input logic [6:0] op);
		enc_r = {f7, rs2, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
			input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] op);
		enc_i = {imm, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
			input logic [4:0] rs1);
		enc_s = {imm[11:5], rs2, rs1, F3_D, imm[4:0], OP_SD};
	endfunction

	function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
			input logic [4:0] rs1, input logic [2:0] f3);
		enc_b = {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BR};
	endfunction

	// Part of the well-formed mix loads x1..x7 with small values as memory pointers; other writes may overwrite them.
	function automatic logic [31:0] rand_instruction();
		int k;
		logic [4:0] rd, rs1, rs2;
		logic [2:0] f3;
		k = $urandom_range(99);
		rd = $urandom_range(31);
		rs1 = $urandom_range(31);
		rs2 = $urandom_range(31);
		f3 = $urandom_range(7);
		if (k < 22) begin
			rand_instruction = enc_r(($urandom_range(3) == 0 && f3 == 3'd0) ? F7_SUB : 7'd0,
				rs2, rs1, f3, rd, OP_R);
		end else if (k < 42) begin
			if (f3 == 3'd1 || f3 == 3'd5)
				rand_instruction = enc_i({6'd0, 6'($urandom_range(63))}, rs1, f3, rd, OP_I);
			else
				rand_instruction = enc_i(12'($urandom), rs1, f3 == 3'd3 ? 3'd0 : f3, rd, OP_I);
		end else if (k < 50) begin
			rand_instruction = enc_i(12'($urandom_range(255)), 5'd0, 3'd0,
				5'($urandom_range(1, 7)), OP_I);
		end else if (k < 62) begin
			rand_instruction = enc_i(12'($urandom_range(127)), 5'($urandom_range(7)), F3_D,
				rd, OP_LD);
		end else if (k < 74) begin
			rand_instruction = enc_s(12'($urandom_range(127)), rs2, 5'($urandom_range(7)));
		end else if (k < 88) begin
			rand_instruction = enc_b(13'($urandom_range(8191)) & 13'h1FF0 | 13'h8, rs2, rs1,
				$urandom_range(1) ? 3'($urandom_range(1)) : 3'($urandom_range(4, 7)));
		end else begin
			rand_instruction = $urandom;
		end
	endfunction

	task automatic send_beat(input logic [31:0] ins);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		instruction <= ins;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_last(input logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [31:0] directed[$];
		int pct[4][2];
		logic [31:0] limits[4];
		pct = '{'{0, 0}, '{51, 0}, '{0, 51}, '{22, 22}};
		limits = '{32'h0000_0040, 32'd0, 32'h0000_0800, 32'hFFFF_FFFC};
		directed = '{
			enc_i(12'h7FF, 5'd0, 3'd0, 5'd1, OP_I),
			enc_i(12'h800, 5'd0, 3'd0, 5'd2, OP_I),
			enc_i(12'h010, 5'd0, 3'd0, 5'd0, OP_I),
			enc_r(7'd0, 5'd2, 5'd1, 3'd0, 5'd3, OP_R),
			enc_r(F7_SUB, 5'd1, 5'd2, 3'd0, 5'd4, OP_R),
			enc_r(7'd0, 5'd1, 5'd2, 3'd1, 5'd5, OP_R),
			enc_r(7'd0, 5'd1, 5'd2, 3'd2, 5'd6, OP_R),
			enc_r(7'd0, 5'd1, 5'd2, 3'd4, 5'd7, OP_R),
			enc_r(7'd0, 5'd1, 5'd2, 3'd5, 5'd8, OP_R),
			enc_r(7'd0, 5'd1, 5'd2, 3'd6, 5'd9, OP_R),
			enc_r(7'd0, 5'd1, 5'd2, 3'd7, 5'd10, OP_R),
			enc_i(12'h03F, 5'd2, 3'd1, 5'd11, OP_I),
			enc_i(12'h03F, 5'd2, 3'd5, 5'd12, OP_I),
			enc_i(12'h800, 5'd2, 3'd2, 5'd13, OP_I),
			enc_i(12'hFFF, 5'd1, 3'd4, 5'd14, OP_I),
			enc_s(12'h0FF, 5'd1, 5'd0),
			enc_i(12'h0FF, 5'd0, F3_D, 5'd15, OP_LD),
			enc_i(12'h100, 5'd0, F3_D, 5'd16, OP_LD),
			enc_s(12'hFFF, 5'd1, 5'd0),
			enc_b(13'h0008, 5'd1, 5'd1, 3'd0),
			enc_b(13'h1FF8, 5'd2, 5'd1, 3'd4),
			enc_b(13'h0FFE, 5'd2, 5'd1, 3'd7),
			enc_r(7'd1, 5'd1, 5'd2, 3'd0, 5'd17, OP_R),
			enc_i(12'h400, 5'd2, 3'd1, 5'd18, OP_I),
			32'hFFFF_FFFF
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_beat(directed[i]);
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			write_last(limits[ph]);
			send_idle_pct = pct[ph][0];
			recv_stall_pct = pct[ph][1];
			if (ph == 1)
				hold_off = 300;
			for (int n = 0; n < 220; n++)
				send_beat(rand_instruction());
			// Sender waits here for every outstanding result.
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		$display("Retired %0d of %0d instructions over four idle/stall mixes and four stop",
			retired, sent);
		$display("addresses; %0d branches taken, %0d memory faults.", taken_cnt, fault_cnt);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

[single_cycle_rv64i_subset_core_unit.f]
+incdir+design
design/rv64s_pkg.sv
design/rv64s_front.sv
design/rv64s_queue.sv
design/rv64s_back.sv
design/single_cycle_rv64i_subset_core_unit.sv
sim/rv64s_core_checker.sv
sim/tb.sv
